/* rtl/gri_pkg.sv */
// Shared types, constants and arithmetic helpers for the gyro rotation integrator.
// Used by the controller, the datapath and the top level.
// No dependencies.
package gri_pkg;

    // Number formats
    localparam int MATRIX_FRAC_BITS = 30;
    localparam int RATE_FRAC_BITS   = 16;
    localparam int THETA_SHIFT      = 37 + RATE_FRAC_BITS;

    // Iteration counts of the shared units
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;
    localparam int TMUL_STEPS   = 5;

    // Fixed-point constants (Q30 unless noted)
    localparam logic [30:0]        NS_SCALE    = 31'd1152921505;   // 1e-9 * 2^60
    localparam logic [31:0]        PI_Q30      = 32'd3373259426;
    localparam logic [31:0]        HALF_PI_Q30 = 32'd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [31:0] ID_DIAG     = 32'sd1 <<< MATRIX_FRAC_BITS;

    typedef logic signed [31:0] q30_t;
    typedef q30_t mat_t [9];

    // One input item
    typedef struct packed {
        logic               window_start;
        logic               window_end;
        logic [62:0]        time_ns;
        logic signed [23:0] rate_x;
        logic signed [23:0] rate_y;
        logic signed [23:0] rate_z;
    } sample_t;

    // Datapath operations
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_DECIDE,
        DP_INIT_ROT,
        DP_SQUARE,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_QMUL,
        DP_TMUL,
        DP_THETA,
        DP_ITER_INIT,
        DP_ITER,
        DP_POST,
        DP_MAC_K2,
        DP_MAC_DR,
        DP_MAC_NR,
        DP_COPY,
        DP_FINISH,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] step;
        logic [1:0] row;
        logic [1:0] col;
        logic [1:0] term;
    } dp_cmd_t;

    typedef struct packed {
        logic win_start;
        logic win_end;
        logic time_after;
        logic mag_zero;
        logic theta_zero;
        logic out_free;
    } dp_status_t;

    // CORDIC arctangent table, Q30
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'd843314857;
            5'd1:    r = 32'd497837830;
            5'd2:    r = 32'd263043837;
            5'd3:    r = 32'd133525159;
            5'd4:    r = 32'd67021687;
            5'd5:    r = 32'd33543516;
            5'd6:    r = 32'd16775851;
            5'd7:    r = 32'd8388437;
            5'd8:    r = 32'd4194283;
            5'd9:    r = 32'd2097149;
            5'd10:   r = 32'd1048576;
            5'd11:   r = 32'd524288;
            5'd12:   r = 32'd262144;
            5'd13:   r = 32'd131072;
            5'd14:   r = 32'd65536;
            5'd15:   r = 32'd32768;
            5'd16:   r = 32'd16384;
            5'd17:   r = 32'd8192;
            5'd18:   r = 32'd4096;
            5'd19:   r = 32'd2048;
            5'd20:   r = 32'd1024;
            5'd21:   r = 32'd512;
            5'd22:   r = 32'd256;
            5'd23:   r = 32'd128;
            5'd24:   r = 32'd64;
            5'd25:   r = 32'd32;
            5'd26:   r = 32'd16;
            5'd27:   r = 32'd8;
            5'd28:   r = 32'd4;
            5'd29:   r = 32'd2;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // Product shifted right by 30, rounding half away from zero
    function automatic logic signed [37:0] rshr30(input logic signed [67:0] v);
        logic [67:0] m;
        logic [37:0] r;
        m = v[67] ? 68'(-v) : 68'(v);
        r = 38'((m + 68'(1 << 29)) >> 30);
        return v[67] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh007FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -40'sh0080000000)
            r = -32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Skew matrix entry of the unit axis, row-major index
    function automatic logic signed [33:0] k_entry(input logic signed [31:0] u0,
                                                   input logic signed [31:0] u1,
                                                   input logic signed [31:0] u2,
                                                   input logic [3:0] idx);
        logic signed [33:0] r;
        case (idx)
            4'd1:    r = -34'(u2);
            4'd2:    r = 34'(u1);
            4'd3:    r = 34'(u2);
            4'd5:    r = -34'(u0);
            4'd6:    r = -34'(u1);
            4'd7:    r = 34'(u0);
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/gri_if.sv */
// Valid/ready channel interfaces for gyro samples in and rotation matrices out.
// No dependencies.
interface gri_in_if;
    logic               valid;
    logic               ready;
    logic               window_start;
    logic               window_end;
    logic [62:0]        time_ns;
    logic signed [23:0] rate_x;
    logic signed [23:0] rate_y;
    logic signed [23:0] rate_z;

    modport source (output valid, window_start, window_end, time_ns, rate_x, rate_y, rate_z,
                    input ready);
    modport sink   (input valid, window_start, window_end, time_ns, rate_x, rate_y, rate_z,
                    output ready);
endinterface

interface gri_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

/* rtl/gyro_rotation_integrator.sv */
// Top level of the gyro rotation integrator: channel wiring, controller and datapath.
// Depends on gri_pkg, gri_if, gri_controller and gri_datapath.
//
//   channel  | dir | payload                                       | handshake
//   in_ch    | in  | window_start, window_end, time_ns, rate_x/y/z | valid/ready
//   out_ch   | out | m00 .. m22, Q2.30                             | valid/ready
//
// One sample at a time. A sample that only sets the reference or has non-positive
// dt, a zero-rate skip and a zero-theta skip end early; a full update runs the 32-step
// square root, the 31-step CORDIC/divider loop and 72 products through the single MAC.
// Reset clears the sequencer, the time reference and loads the identity matrix.
// A finished matrix waits in the output register; the next sample is accepted
// meanwhile, and a later window end holds until that register is free.
module gyro_rotation_integrator (
    input logic     clk,
    input logic     rst_n,
    gri_in_if.sink  in_ch,
    gri_out_if.source out_ch
);
    import gri_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    sample_t    sample;
    mat_t       mat;
    logic       in_ready;
    logic       out_valid;

    assign sample = '{window_start: in_ch.window_start, window_end: in_ch.window_end,
                      time_ns: in_ch.time_ns, rate_x: in_ch.rate_x,
                      rate_y: in_ch.rate_y, rate_z: in_ch.rate_z};

    gri_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    gri_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (sample),
        .out_ready (out_ch.ready),
        .status    (status),
        .out_valid (out_valid),
        .out_mat   (mat)
    );

    assign in_ch.ready  = in_ready;
    assign out_ch.valid = out_valid;
    assign out_ch.m00   = mat[0];
    assign out_ch.m01   = mat[1];
    assign out_ch.m02   = mat[2];
    assign out_ch.m10   = mat[3];
    assign out_ch.m11   = mat[4];
    assign out_ch.m12   = mat[5];
    assign out_ch.m20   = mat[6];
    assign out_ch.m21   = mat[7];
    assign out_ch.m22   = mat[8];

endmodule

/* rtl/gri_datapath.sv */
// Datapath: sqrt, wide time multiply, CORDIC, axis dividers, shared MAC, matrix state.
// Driven by gri_controller through dp_cmd_t; depends on gri_pkg.
module gri_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  gri_pkg::dp_cmd_t    cmd,
    input  gri_pkg::sample_t    sample,
    input  logic                out_ready,
    output gri_pkg::dp_status_t status,
    output logic                out_valid,
    output gri_pkg::mat_t       out_mat
);
    import gri_pkg::*;

    typedef struct packed {
        logic       valid;
        dp_op_t     op;
        logic [3:0] e;
        logic       first;
        logic       last;
    } mac_tag_t;

    // Latched item and time state
    logic               start_reg;
    logic               end_reg;
    logic [62:0]        time_reg;
    logic [62:0]        prev_time_reg;
    logic [62:0]        dt_reg;
    logic signed [23:0] rate_reg [3];

    // Magnitude and angle
    logic [47:0]  sumsq_reg;
    logic [63:0]  sq_v_reg;
    logic [63:0]  sq_res_reg;
    logic [63:0]  sq_bit_reg;
    logic [61:0]  q_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic [127:0] big_reg;
    logic [31:0]  theta_reg;

    // CORDIC and dividers
    logic               flip_reg;
    logic signed [33:0] cx_reg;
    logic signed [33:0] cy_reg;
    logic signed [33:0] cz_reg;
    logic [31:0]        rem_reg [3];
    logic [30:0]        quo_reg [3];
    logic signed [33:0] sn_reg;
    logic signed [33:0] omc_reg;
    logic signed [31:0] u_reg [3];

    // MAC and matrices
    logic signed [67:0] prod_reg;
    mac_tag_t           tag_reg;
    logic signed [39:0] acc_reg;
    logic signed [33:0] k2_reg [9];
    logic signed [31:0] dr_reg [9];
    logic signed [31:0] nr_reg [9];
    logic signed [31:0] rot_reg [9];
    logic signed [31:0] out_mat_reg [9];
    logic               out_valid_reg;

    logic [30:0]        mag;
    logic [23:0]        abs_r;
    logic [47:0]        sq_prod;
    logic [63:0]        sq_sum;
    logic [61:0]        q_prod;
    logic [31:0]        limb_a;
    logic [31:0]        limb_b;
    logic [63:0]        pp_prod;
    logic [127:0]       pp_shifted;
    logic               theta_over;
    logic [31:0]        fold_ang;
    logic signed [33:0] cx_sh;
    logic signed [33:0] cy_sh;
    logic signed [33:0] atan_val;
    logic [3:0]         e_idx;
    logic [3:0]         ia_idx;
    logic [3:0]         ib_idx;
    logic signed [33:0] mac_a;
    logic signed [33:0] mac_b;
    logic               mac_issue;
    logic [1:0]         last_term;
    logic signed [37:0] mac_rp;
    logic signed [39:0] mac_base;
    logic signed [39:0] mac_sum;
    logic               e_diag;

    assign mag = sq_res_reg[30:0];

    // Sum of squares operand
    always_comb
    begin
        abs_r = rate_reg[cmd.step[1:0]][23] ? 24'(-rate_reg[cmd.step[1:0]])
                                            : 24'(rate_reg[cmd.step[1:0]]);
    end
    assign sq_prod = abs_r * abs_r;
    assign sq_sum  = sq_res_reg + sq_bit_reg;

    // Time multiply: mag * scale, then 2x2 limb products of q * dt
    assign q_prod = mag * NS_SCALE;
    assign limb_a = cmd.step[1] ? {2'b00, q_reg[61:32]} : q_reg[31:0];
    assign limb_b = cmd.step[0] ? {1'b0, dt_reg[62:32]} : dt_reg[31:0];
    assign pp_prod = limb_a * limb_b;

    always_comb
    begin
        case (pp_sh_reg)
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = {64'd0, pp_reg};
        endcase
    end

    // Theta saturation and folding into [0, pi/2]
    assign theta_over = (|big_reg[127:THETA_SHIFT+32])
                     || (big_reg[THETA_SHIFT+31:THETA_SHIFT] > PI_Q30);
    assign fold_ang   = (theta_reg > HALF_PI_Q30) ? PI_Q30 - theta_reg : theta_reg;

    // CORDIC shifts
    assign cx_sh    = cx_reg >>> cmd.step;
    assign cy_sh    = cy_reg >>> cmd.step;
    assign atan_val = $signed({2'b00, atan_q30(cmd.step)});

    // MAC operand selection
    assign e_idx  = 4'({cmd.row, 1'b0}) + 4'(cmd.row) + 4'(cmd.col);
    assign ia_idx = 4'({cmd.row, 1'b0}) + 4'(cmd.row) + 4'(cmd.term);
    assign ib_idx = 4'({cmd.term, 1'b0}) + 4'(cmd.term) + 4'(cmd.col);

    always_comb
    begin
        mac_a     = 34'sd0;
        mac_b     = 34'sd0;
        mac_issue = 1'b1;
        last_term = 2'd2;
        case (cmd.op)
            DP_MAC_K2:
            begin
                mac_a = k_entry(u_reg[0], u_reg[1], u_reg[2], ia_idx);
                mac_b = k_entry(u_reg[0], u_reg[1], u_reg[2], ib_idx);
            end
            DP_MAC_DR:
            begin
                last_term = 2'd1;
                if (cmd.term == 2'd0)
                begin
                    mac_a = sn_reg;
                    mac_b = k_entry(u_reg[0], u_reg[1], u_reg[2], e_idx);
                end
                else
                begin
                    mac_a = omc_reg;
                    mac_b = k2_reg[e_idx];
                end
            end
            DP_MAC_NR:
            begin
                mac_a = 34'(dr_reg[ia_idx]);
                mac_b = 34'(rot_reg[ib_idx]);
            end
            default: mac_issue = 1'b0;
        endcase
    end

    // MAC accumulate stage
    assign e_diag   = (tag_reg.e == 4'd0) || (tag_reg.e == 4'd4) || (tag_reg.e == 4'd8);
    assign mac_rp   = rshr30(prod_reg);
    always_comb
    begin
        if (!tag_reg.first)
            mac_base = acc_reg;
        else if (tag_reg.op == DP_MAC_DR && e_diag)
            mac_base = 40'(ONE_Q30);
        else
            mac_base = 40'sd0;
    end
    assign mac_sum = mac_base + 40'(mac_rp);

    // State with reset: matrix, time reference, output handshake, MAC tag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                rot_reg[i] <= (i % 4 == 0) ? ID_DIAG : 32'sd0;
            prev_time_reg <= '0;
            out_valid_reg <= 1'b0;
            tag_reg       <= '0;
        end
        else
        begin
            tag_reg <= '{valid: mac_issue, op: cmd.op, e: e_idx,
                         first: (cmd.term == 2'd0), last: (cmd.term == last_term)};
            if (cmd.op == DP_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                DP_INIT_ROT:
                begin
                    for (int i = 0; i < 9; i++)
                        rot_reg[i] <= (i % 4 == 0) ? ID_DIAG : 32'sd0;
                end
                DP_COPY:
                begin
                    for (int i = 0; i < 9; i++)
                        rot_reg[i] <= nr_reg[i];
                end
                DP_FINISH:
                    prev_time_reg <= time_reg;
                DP_EMIT:
                begin
                    prev_time_reg <= time_reg;
                    for (int i = 0; i < 9; i++)
                        rot_reg[i] <= (i % 4 == 0) ? ID_DIAG : 32'sd0;
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                start_reg   <= sample.window_start;
                end_reg     <= sample.window_end;
                time_reg    <= sample.time_ns;
                rate_reg[0] <= sample.rate_x;
                rate_reg[1] <= sample.rate_y;
                rate_reg[2] <= sample.rate_z;
            end
            DP_DECIDE:
            begin
                dt_reg    <= time_reg - prev_time_reg;
                sumsq_reg <= '0;
            end
            DP_SQUARE:
                sumsq_reg <= sumsq_reg + sq_prod;
            DP_SQRT_INIT:
            begin
                sq_v_reg   <= {2'b00, sumsq_reg, 14'd0};
                sq_res_reg <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
            end
            DP_SQRT_STEP:
            begin
                if (sq_v_reg >= sq_sum)
                begin
                    sq_v_reg   <= sq_v_reg - sq_sum;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                    sq_res_reg <= sq_res_reg >> 1;
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            DP_QMUL:
            begin
                q_reg   <= q_prod;
                big_reg <= '0;
            end
            DP_TMUL:
            begin
                pp_reg    <= pp_prod;
                pp_sh_reg <= 2'(cmd.step[1]) + 2'(cmd.step[0]);
                if (cmd.step != 5'd0)
                    big_reg <= big_reg + pp_shifted;
            end
            DP_THETA:
                theta_reg <= theta_over ? PI_Q30 : big_reg[THETA_SHIFT+31:THETA_SHIFT];
            DP_ITER_INIT:
            begin
                flip_reg <= theta_reg > HALF_PI_Q30;
                cx_reg   <= CORDIC_GAIN;
                cy_reg   <= 34'sd0;
                cz_reg   <= $signed({2'b00, fold_ang});
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[l] <= rate_reg[l][23] ? {2'b00, 24'(-rate_reg[l]), 6'd0}
                                                  : {2'b00, 24'(rate_reg[l]), 6'd0};
                    quo_reg[l] <= '0;
                end
            end
            DP_ITER:
            begin
                // One CORDIC rotation (steps below CORDIC_STEPS) and one quotient bit per lane
                if (cmd.step < 5'(CORDIC_STEPS))
                begin
                    if (!cz_reg[33])
                    begin
                        cx_reg <= cx_reg - cy_sh;
                        cy_reg <= cy_reg + cx_sh;
                        cz_reg <= cz_reg - atan_val;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + cy_sh;
                        cy_reg <= cy_reg - cx_sh;
                        cz_reg <= cz_reg + atan_val;
                    end
                end
                for (int l = 0; l < 3; l++)
                begin
                    if ({rem_reg[l][30:0], 1'b0} >= {1'b0, mag})
                    begin
                        rem_reg[l] <= {rem_reg[l][30:0], 1'b0} - {1'b0, mag};
                        quo_reg[l] <= {quo_reg[l][29:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[l] <= {rem_reg[l][30:0], 1'b0};
                        quo_reg[l] <= {quo_reg[l][29:0], 1'b0};
                    end
                end
            end
            DP_POST:
            begin
                sn_reg  <= cy_reg;
                omc_reg <= flip_reg ? ONE_Q30 + cx_reg : ONE_Q30 - cx_reg;
                for (int l = 0; l < 3; l++)
                begin
                    if (quo_reg[l] > 31'(ONE_Q30))
                        u_reg[l] <= rate_reg[l][23] ? -32'(ONE_Q30) : 32'(ONE_Q30);
                    else
                        u_reg[l] <= rate_reg[l][23] ? -32'(quo_reg[l]) : 32'(quo_reg[l]);
                end
            end
            default: ;
        endcase

        // Shared multiplier
        if (mac_issue)
            prod_reg <= mac_a * mac_b;

        // Accumulate and write back finished entries
        if (tag_reg.valid)
        begin
            acc_reg <= mac_sum;
            if (tag_reg.last)
            begin
                case (tag_reg.op)
                    DP_MAC_K2: k2_reg[tag_reg.e] <= 34'(mac_sum);
                    DP_MAC_DR: dr_reg[tag_reg.e] <= sat32(mac_sum);
                    DP_MAC_NR: nr_reg[tag_reg.e] <= sat32(mac_sum);
                    default: ;
                endcase
            end
        end

        if (cmd.op == DP_EMIT)
        begin
            for (int i = 0; i < 9; i++)
                out_mat_reg[i] <= rot_reg[i];
        end
    end

    // Status to the controller
    assign status = '{win_start: start_reg, win_end: end_reg,
                      time_after: (time_reg > prev_time_reg),
                      mag_zero: (sq_res_reg == 64'd0),
                      theta_zero: (theta_reg == 32'd0),
                      out_free: (!out_valid_reg || out_ready)};

    assign out_valid = out_valid_reg;
    assign out_mat   = out_mat_reg;

    // Checks
    a_theta_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_ITER_INIT |-> theta_reg <= PI_Q30)
        else $error("theta above pi at CORDIC start");

    a_axis_unit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_POST |-> quo_reg[0] <= 31'(ONE_Q30))
        else $error("axis quotient above one");

    a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.op == DP_EMIT))
        else $error("output valid without emit");

endmodule

/* rtl/gri_controller.sv */
// Sequencer for one gyro sample: reference handling, magnitude, angle, Rodrigues update.
// Commands gri_datapath through dp_cmd_t; depends on gri_pkg.
module gri_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  gri_pkg::dp_status_t status,
    output logic                in_ready,
    output gri_pkg::dp_cmd_t    cmd
);
    import gri_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECIDE,
        S_SQUARE,
        S_SQRT_INIT,
        S_SQRT,
        S_QMUL,
        S_TMUL,
        S_THETA,
        S_ITER_INIT,
        S_ITER,
        S_POST,
        S_K2,
        S_DR,
        S_NR,
        S_DRAIN,
        S_COPY,
        S_FINISH
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [4:0] cnt_reg;
    logic [4:0] cnt_next;
    logic [1:0] row_reg;
    logic [1:0] row_next;
    logic [1:0] col_reg;
    logic [1:0] col_next;
    logic [1:0] term_reg;
    logic [1:0] term_next;
    logic       have_ref_reg;
    logic       have_ref_next;
    logic       mac_done;
    logic [1:0] last_term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            term_reg     <= '0;
            have_ref_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            term_reg     <= term_next;
            have_ref_reg <= have_ref_next;
        end
    end

    // MAC walk: terms inside entries, entries row-major
    assign last_term = (state_reg == S_DR) ? 2'd1 : 2'd2;
    assign mac_done  = (term_reg == last_term) && (col_reg == 2'd2) && (row_reg == 2'd2);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        term_next     = term_reg;
        have_ref_next = have_ref_reg;
        in_ready      = 1'b0;
        cmd           = '{op: DP_NOP, step: cnt_reg, row: row_reg, col: col_reg,
                          term: term_reg};

        if (state_reg == S_K2 || state_reg == S_DR || state_reg == S_NR)
        begin
            if (term_reg != last_term)
                term_next = term_reg + 2'd1;
            else
            begin
                term_next = 2'd0;
                if (col_reg != 2'd2)
                    col_next = col_reg + 2'd1;
                else
                begin
                    col_next = 2'd0;
                    row_next = (row_reg == 2'd2) ? 2'd0 : row_reg + 2'd1;
                end
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (status.win_start || !have_ref_reg)
                begin
                    cmd.op        = DP_INIT_ROT;
                    have_ref_next = 1'b1;
                    state_next    = S_FINISH;
                end
                else if (status.time_after)
                begin
                    cmd.op     = DP_DECIDE;
                    cnt_next   = '0;
                    state_next = S_SQUARE;
                end
                else
                    state_next = S_FINISH;
            end
            S_SQUARE:
            begin
                cmd.op = DP_SQUARE;
                if (cnt_reg == 5'd2)
                begin
                    cnt_next   = '0;
                    state_next = S_SQRT_INIT;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_SQRT_INIT:
            begin
                cmd.op     = DP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = DP_SQRT_STEP;
                if (cnt_reg == 5'(SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_QMUL;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_QMUL:
            begin
                if (status.mag_zero)
                    state_next = S_FINISH;
                else
                begin
                    cmd.op     = DP_QMUL;
                    cnt_next   = '0;
                    state_next = S_TMUL;
                end
            end
            S_TMUL:
            begin
                cmd.op = DP_TMUL;
                if (cnt_reg == 5'(TMUL_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_THETA;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_THETA:
            begin
                cmd.op     = DP_THETA;
                state_next = S_ITER_INIT;
            end
            S_ITER_INIT:
            begin
                if (status.theta_zero)
                    state_next = S_FINISH;
                else
                begin
                    cmd.op     = DP_ITER_INIT;
                    cnt_next   = '0;
                    state_next = S_ITER;
                end
            end
            S_ITER:
            begin
                cmd.op = DP_ITER;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_POST;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            S_POST:
            begin
                cmd.op     = DP_POST;
                row_next   = '0;
                col_next   = '0;
                term_next  = '0;
                state_next = S_K2;
            end
            S_K2:
            begin
                cmd.op = DP_MAC_K2;
                if (mac_done)
                    state_next = S_DR;
            end
            S_DR:
            begin
                cmd.op = DP_MAC_DR;
                if (mac_done)
                    state_next = S_NR;
            end
            S_NR:
            begin
                cmd.op = DP_MAC_NR;
                if (mac_done)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
                state_next = S_COPY;
            S_COPY:
            begin
                cmd.op     = DP_COPY;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.win_end)
                begin
                    if (status.out_free)
                    begin
                        cmd.op        = DP_EMIT;
                        have_ref_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    cmd.op     = DP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Checks
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_EMIT |-> status.out_free)
        else $error("emit over an untaken result");

    a_emit_drops_ref: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_EMIT |=> !have_ref_reg)
        else $error("reference kept after emit");

endmodule

/* tb/sv/gri_tb_checker.sv */
// Checker for the gyro rotation integrator: watches both channels, predicts each
// window's rotation matrix from the accepted samples and compares the results.
// Depends on gri_pkg and gri_if.
module gri_tb_checker (
    input  logic      clk,
    input  logic      rst_n,
    gri_in_if.sink    in_mon,
    gri_out_if.sink   out_mon,
    output int        fail_count,
    output int        pending,
    output int        matrix_count,
    output int        update_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import gri_pkg::*;

    localparam longint ONE   = 64'sd1073741824;
    localparam longint PI    = 64'sd3373259426;
    localparam longint HPI   = 64'sd1686629713;
    localparam longint GAIN  = 64'sd652032874;
    localparam longint SCALE = 64'sd1152921505;

    typedef logic signed [31:0] entry_t;
    typedef struct {
        entry_t m [9];
    } rot_t;

    entry_t   rot_state [9];
    bit [62:0] ref_time;
    bit       have_ref;
    rot_t     rot_queue [$];

    // Signed shift right by 30, rounding half away from zero
    function automatic longint round30(input longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 << 29)) >>> 30;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint arctan_step(input int i);
        longint tab [30] = '{843314857, 497837830, 263043837, 133525159, 67021687,
            33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
            32, 16, 8, 4, 2};
        return tab[i];
    endfunction

    task automatic load_identity();
        for (int i = 0; i < 9; i++)
            rot_state[i] = (i % 4 == 0) ? entry_t'(ONE) : '0;
    endtask

    // Premultiply the running rotation by the increment over dt
    task automatic rotate_by_rate(input longint rx, input longint ry, input longint rz,
                                  input bit [62:0] dt);
        longint r [3];
        longint u [3];
        longint k [9];
        longint k2 [9];
        longint dr [9];
        longint nr [9];
        bit [63:0] sumsq;
        bit [63:0] rem;
        bit [63:0] root;
        bit [63:0] bitv;
        bit [127:0] prod;
        bit [127:0] th;
        bit [63:0] a;
        bit [63:0] v;
        longint theta;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint sn;
        longint cs;
        longint omc;
        longint acc;
        r[0] = rx; r[1] = ry; r[2] = rz;
        sumsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            a = (r[i] < 0) ? -r[i] : r[i];
            sumsq += a * a;
        end
        rem = sumsq << 14;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        if (root == 0)
            return;
        // theta from magnitude and dt, saturated at pi
        prod = 128'(root * 64'(SCALE)) * 128'(dt);
        th = prod >> (37 + RATE_FRAC_BITS);
        theta = (th > 128'(PI)) ? PI : longint'(th);
        if (theta == 0)
            return;
        update_count++;
        for (int i = 0; i < 3; i++)
        begin
            a = (r[i] < 0) ? -r[i] : r[i];
            v = (a << 37) / root;
            if (v > 64'(ONE))
                v = ONE;
            u[i] = (r[i] < 0) ? -longint'(v) : longint'(v);
        end
        // CORDIC on theta folded into the first quadrant
        x = GAIN; y = 0;
        z = (theta > HPI) ? PI - theta : theta;
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= arctan_step(i);
            end
            else
            begin
                nx = x + (y >>> i); y = y - (x >>> i); z += arctan_step(i);
            end
            x = nx;
        end
        sn = y;
        cs = (theta > HPI) ? -x : x;
        omc = ONE - cs;
        k = '{0, -u[2], u[1], u[2], 0, -u[0], -u[1], u[0], 0};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int m = 0; m < 3; m++)
                    acc += round30(k[i*3+m] * k[m*3+j]);
                k2[i*3+j] = acc;
            end
        for (int i = 0; i < 9; i++)
            dr[i] = clamp32(((i % 4 == 0) ? ONE : 0) + round30(sn * k[i])
                            + round30(omc * k2[i]));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int m = 0; m < 3; m++)
                    acc += round30(dr[i*3+m] * longint'(rot_state[m*3+j]));
                nr[i*3+j] = clamp32(acc);
            end
        for (int i = 0; i < 9; i++)
            rot_state[i] = entry_t'(nr[i]);
    endtask

    task automatic predict_sample();
        rot_t res;
        if (in_mon.window_start || !have_ref)
        begin
            load_identity();
            have_ref = 1'b1;
        end
        else if (in_mon.time_ns > ref_time)
            rotate_by_rate(in_mon.rate_x, in_mon.rate_y, in_mon.rate_z,
                           in_mon.time_ns - ref_time);
        ref_time = in_mon.time_ns;
        if (in_mon.window_end)
        begin
            res.m = rot_state;
            rot_queue.insert(rot_queue.size(), res);
            load_identity();
            have_ref = 1'b0;
        end
    endtask

    task automatic compare_matrix();
        rot_t   exp_r;
        entry_t got [9];
        got = '{out_mon.m00, out_mon.m01, out_mon.m02, out_mon.m10, out_mon.m11,
                out_mon.m12, out_mon.m20, out_mon.m21, out_mon.m22};
        if (rot_queue.size() == 0)
        begin
            $display("%0t: unexpected matrix, m00 %0d", $realtime, got[0]);
            fail_count++;
            return;
        end
        exp_r = rot_queue.pop_front();
        matrix_count++;
        for (int i = 0; i < 9; i++)
            if (got[i] !== exp_r.m[i])
            begin
                $display("%0t: m%0d%0d expected %0d actual %0d", $realtime, i / 3, i % 3,
                         exp_r.m[i], got[i]);
                fail_count++;
            end
    endtask

    initial
    begin
        fail_count = 0;
        matrix_count = 0;
        update_count = 0;
        pending = 0;
        load_identity();
        ref_time = '0;
        have_ref = 1'b0;
    end

    // Sample both channels at the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_mon.valid && out_mon.ready)
                compare_matrix();
            if (in_mon.valid && in_mon.ready)
                predict_sample();
            pending = rot_queue.size();
        end
    end
endmodule

/* tb/sv/tb_gyro_rotation_integrator.sv */
// Top of the gyro rotation integrator testbench: clock, reset, sample stimulus,
// output stalls and the verdict. Depends on gri_pkg, gri_if and gri_tb_checker.
module tb_gyro_rotation_integrator;
    timeunit 1ns;
    timeprecision 1ps;

    import gri_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   matrix_count;
    int   update_count;
    bit   calm;          // no idling in the last part
    bit   hold_long;     // long receiver stall requested
    bit   hold_done;
    logic [62:0] now_ns;

    gri_in_if  in_ch ();
    gri_out_if out_ch ();

    gyro_rotation_integrator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    gri_tb_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mon       (in_ch.sink),
        .out_mon      (out_ch.sink),
        .fail_count   (fail_count),
        .pending      (pending),
        .matrix_count (matrix_count),
        .update_count (update_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.window_start = 1'b0;
        in_ch.window_end = 1'b0;
        in_ch.time_ns = '0;
        in_ch.rate_x = '0;
        in_ch.rate_y = '0;
        in_ch.rate_z = '0;
        out_ch.ready = 1'b0;
        calm = 1'b0;
        hold_long = 1'b0;
        hold_done = 1'b0;
        now_ns = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Receiver: random stall bursts, one long stall on request
    initial
    begin
        int gap;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_long && !hold_done)
            begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 19);
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    function automatic logic signed [23:0] pick_rate();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            2: return 24'(signed'($urandom_range(0, 64)) - 32);
            default: return 24'($urandom);
        endcase
    endfunction

    // Offer one sample and wait for it to be taken
    task automatic send_sample(input bit ws, input bit we, input logic [62:0] t,
                               input logic signed [23:0] rx, input logic signed [23:0] ry,
                               input logic signed [23:0] rz);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.window_start <= ws;
        in_ch.window_end <= we;
        in_ch.time_ns <= t;
        in_ch.rate_x <= rx;
        in_ch.rate_y <= ry;
        in_ch.rate_z <= rz;
        @(posedge clk iff in_ch.ready);
    endtask

    task automatic drop_valid();
        in_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // A window of n samples, timestamps mostly non-decreasing with an occasional step back
    task automatic send_window(input int n, input int step_max);
        for (int i = 0; i < n; i++)
        begin
            now_ns += 63'($urandom_range(0, step_max));
            if ($urandom_range(0, 30) == 0)
                now_ns -= 63'($urandom_range(0, 1000));
            send_sample(i == 0, i == n - 1, now_ns, pick_rate(), pick_rate(), pick_rate());
        end
    endtask

    initial
    begin
        int cycles;
        @(posedge clk iff rst_n);
        // Directed: extremes, skips, saturation, start+end together, no reference
        send_sample(1, 1, 63'd0, 24'sh7FFFFF, -24'sh800000, 24'sd0);
        send_sample(0, 0, 63'd100, 24'sd1000, 24'sd0, 24'sd0);         // no reference
        send_sample(0, 0, 63'd2000000, 24'sd65536, 24'sd0, 24'sd0);
        send_sample(0, 0, 63'd2000000, 24'sd65536, 24'sd0, 24'sd0);    // dt zero
        send_sample(0, 0, 63'd1000, 24'sd0, 24'sd65536, 24'sd0);       // dt negative
        send_sample(0, 0, 63'd5000000, 24'sd0, 24'sd0, 24'sd0);        // zero rate
        send_sample(0, 0, 63'd5000001, 24'sd1, 24'sd0, 24'sd0);        // theta zero
        send_sample(0, 0, 63'd8000000, -24'sd65536, 24'sd30000, 24'sd40000);
        send_sample(0, 1, 63'h7FFFFFFFFFFFFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                    24'sh7FFFFF);                                       // theta saturates
        send_sample(1, 0, 63'd0, 24'sd0, 24'sd0, 24'sd0);
        send_sample(0, 0, 63'd1500000000, -24'sh800000, -24'sh800000, -24'sh800000);
        send_sample(0, 0, 63'd1600000000, 24'sd0, 24'sd0, -24'sd205887);
        send_sample(1, 0, 63'h555555555555555, 24'sh555555, -24'sh2AAAAB, 24'sd3);
        send_sample(0, 1, 63'h2AAAAAAAAAAAAAA, 24'sd7, 24'sd7, 24'sd7);
        send_sample(0, 1, 63'd10, 24'sd100, 24'sd100, 24'sd100);
        // Sender pause until every expected matrix is out
        drop_valid();
        cycles = 0;
        while (pending != 0 && cycles < 100000)
        begin
            @(posedge clk);
            cycles++;
        end
        // Long receiver stall while windows keep coming
        hold_long = 1'b1;
        for (int w = 0; w < 8; w++)
            send_window(1 + $urandom_range(0, 1), 20000000);
        // Random windows, mostly well-formed, some noise
        for (int w = 0; w < 215; w++)
        begin
            if (w == 185)
                calm = 1'b1;
            if ($urandom_range(0, 7) == 0)
                send_sample($urandom_range(0, 1), $urandom_range(0, 1), 63'({$urandom, $urandom}),
                            24'($urandom), 24'($urandom), 24'($urandom));
            else
                send_window($urandom_range(1, 8),
                            ($urandom_range(0, 3) == 0) ? 2000000000 : 10000000);
        end
        drop_valid();
        cycles = 0;
        while (pending != 0 && cycles < 200000)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (400) @(posedge clk);
        $display("Covered %0d matrices, %0d rotation updates, skips, saturation and stalls.",
                 matrix_count, update_count);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
